@@ src/q6kdot_pkg.sv @@
// q6kdot_pkg: shared types and constants for the q6k by q8k block dot product
// no dependencies; compiled first
`default_nettype none
package q6kdot_pkg;

   localparam int ELEMENTS_PER_ITEM = 16;

   // fp32 codes for invalid operations and nan quieting, and positive zero
   localparam logic [31:0] FP32_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP32_QUIET_BIT   = 32'h0040_0000;
   localparam logic [31:0] FP32_POS_ZERO    = 32'h0000_0000;

   typedef struct packed {
      logic [63:0]        weight_low_nibbles;
      logic [31:0]        weight_high_pairs;
      logic [63:0]        act_first_eight;
      logic [63:0]        act_last_eight;
      logic signed [7:0]  sub_scale;
      logic [15:0]        weight_scale_half;
      logic [31:0]        act_scale_single;
      logic               ends_super_block;
      logic               ends_row;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] row_dot_bits;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_SCALE,
      ST_TOTAL,
      ST_TF_LOAD,
      ST_TF_FIX,
      ST_TF_ROUND,
      ST_D_LOAD,
      ST_D_FIX,
      ST_D_ROUND,
      ST_P_LOAD,
      ST_P_FIX,
      ST_A_LOAD,
      ST_A_FIX,
      ST_ADD,
      ST_R_FIX,
      ST_R_ROUND,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_in;
      logic do_mult;
      logic do_sum;
      logic do_scale;
      logic do_total;
      logic ld_tf;
      logic ld_d;
      logic ld_p;
      logic ld_a;
      logic do_add;
      logic fix_step;
      logic floor_en;
      logic st_tf;
      logic st_d;
      logic st_acc;
      logic spec_d;
      logic spec_acc;
      logic emit;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic fold;
      logic row;
      logic fix_done;
      logic d_special;
      logic fma_special;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ src/q6kdot_chan_if.sv @@
// q6kdot_chan_if: valid/ready channel carrying one payload beat
// payload type is set by the instantiating level
`default_nettype none
interface q6kdot_chan_if #(parameter type payload_type = logic [31:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/q6kdot_datapath.sv @@
// q6kdot_datapath: integer dot stage, shared normalize/round unit, fused accumulate
// depends on q6kdot_pkg
`default_nettype none
module q6kdot_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  q6kdot_pkg::dp_cmd_type       cmd,
   output q6kdot_pkg::dp_stat_type      stat,
   input  q6kdot_pkg::req_payload_type  req_payload,
   output logic [31:0]                  rsp_row_dot_bits
);
   import q6kdot_pkg::*;

   function automatic logic [23:0] f32_sig(input logic [31:0] b);
      return (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
   endfunction

   function automatic logic signed [11:0] f32_exp(input logic [31:0] b);
      return (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
   endfunction

   req_payload_type   in_ff;
   logic signed [13:0] prod_ff [ELEMENTS_PER_ITEM];
   logic signed [13:0] prod_in [ELEMENTS_PER_ITEM];
   logic signed [17:0] sum_ff, sum_in;
   logic signed [25:0] scaled_ff, scaled_in;
   logic [31:0]        total_ff, total_in;
   logic [79:0]        sig_ff, sig_in;
   logic signed [11:0] x_ff, x_in;
   logic               sign_ff, sign_in;
   logic               sticky_ff, sticky_in;
   logic [79:0]        p_sig_ff;
   logic signed [11:0] p_x_ff;
   logic               p_sign_ff;
   logic [31:0]        tf_ff, tf_in;
   logic [31:0]        d_ff, d_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        out_ff;

   // dot product of one sub-block
   always_comb begin
      logic [5:0]         code;
      logic signed [13:0] cw;
      logic signed [13:0] aw;
      logic [7:0]         act;
      logic signed [17:0] acc18;
      logic signed [25:0] sa;
      logic signed [25:0] sb;
      acc18 = '0;
      for (int k = 0; k < ELEMENTS_PER_ITEM; k++) begin
         code = {in_ff.weight_high_pairs[2*k +: 2], in_ff.weight_low_nibbles[4*k +: 4]};
         if (k < 8) begin
            act = in_ff.act_first_eight[8*k +: 8];
         end else begin
            act = in_ff.act_last_eight[8*(k-8) +: 8];
         end
         // code - 32 is the code with its top bit flipped, read as signed
         cw = $signed({{8{~code[5]}}, ~code[5], code[4:0]});
         aw = $signed({{6{act[7]}}, act});
         prod_in[k] = cw * aw;
      end
      for (int k = 0; k < ELEMENTS_PER_ITEM; k++) begin
         acc18 = acc18 + 18'(prod_ff[k]);
      end
      sum_in = acc18;
      sa = 26'(sum_ff);
      sb = 26'(in_ff.sub_scale);
      scaled_in = sa * sb;
   end

   // normalize / denormalize step and fp32 rounding of the working frame
   logic signed [12:0] t_cur;
   logic               nz;
   logic               do_l8, do_l1, do_r8, do_r1;
   logic [31:0]        round_bits;

   always_comb begin
      logic               l8_ok, l1_ok;
      logic signed [12:0] be;
      logic               ovf;
      logic [7:0]         exp_field;
      logic               guard, st, inc;
      logic [30:0]        rnd31;
      t_cur = 13'(x_ff) + 13'sd79;
      nz    = |sig_ff;
      l8_ok = !cmd.floor_en || (t_cur - 13'sd8 >= -13'sd126);
      l1_ok = !cmd.floor_en || (t_cur - 13'sd1 >= -13'sd126);
      do_l8 = nz && (sig_ff[79:72] == 8'd0) && l8_ok;
      do_l1 = !do_l8 && nz && !sig_ff[79] && l1_ok;
      do_r8 = !do_l8 && !do_l1 && cmd.floor_en && nz && (t_cur <= -13'sd134);
      do_r1 = !do_l8 && !do_l1 && !do_r8 && cmd.floor_en && nz && (t_cur < -13'sd126);

      be        = t_cur + 13'sd127;
      ovf       = sig_ff[79] && (be >= 13'sd255);
      exp_field = sig_ff[79] ? be[7:0] : 8'd0;
      guard     = sig_ff[55];
      st        = (|sig_ff[54:0]) | sticky_ff;
      inc       = guard & (st | sig_ff[56]);
      rnd31     = {exp_field, sig_ff[78:56]} + 31'(inc);
      round_bits = ovf ? {sign_ff, 8'hFF, 23'd0} : {sign_ff, rnd31};
   end

   // aligned add of saved product and accumulator
   logic [79:0]        add_sig;
   logic signed [11:0] add_x;
   logic               add_sign;

   always_comb begin
      logic               a_zero, p_zero, p_big;
      logic [79:0]        big_sig, small_sig, big_al, small_sh, small_j;
      logic signed [11:0] big_x, small_x;
      logic               big_s, small_s;
      logic signed [12:0] dx;
      logic [6:0]         sh;
      logic               lost;
      logic [80:0]        d81;
      a_zero = ~|sig_ff;
      p_zero = ~|p_sig_ff;
      p_big  = a_zero || (!p_zero && (p_x_ff >= x_ff));
      big_sig   = p_big ? p_sig_ff : sig_ff;
      small_sig = p_big ? sig_ff : p_sig_ff;
      big_x     = p_big ? p_x_ff : x_ff;
      small_x   = p_big ? x_ff : p_x_ff;
      big_s     = p_big ? p_sign_ff : sign_ff;
      small_s   = p_big ? sign_ff : p_sign_ff;
      dx = 13'(big_x) - 13'(small_x);
      sh = ((dx < 13'sd0) || (dx >= 13'sd79)) ? 7'd80 : 7'(dx + 13'sd1);
      big_al   = big_sig >> 1;
      small_sh = small_sig >> sh;
      lost     = |(small_sig << (7'd80 - sh));
      small_j  = small_sh | {79'd0, lost};
      d81      = '0;
      if (big_s == small_s) begin
         add_sig  = big_al + small_j;
         add_sign = big_s;
      end else begin
         d81 = {1'b0, big_al} - {1'b0, small_j};
         if (d81[80]) begin
            add_sig  = ~d81[79:0] + 80'd1;
            add_sign = small_s;
         end else begin
            add_sig  = d81[79:0];
            add_sign = big_s;
         end
      end
      if (add_sig == 80'd0) begin
         add_sign = p_sign_ff & sign_ff;
      end
      add_x = big_x + 12'sd1;
   end

   // special operands of the scale product and of the fused accumulate
   logic        d_special, fma_special;
   logic [31:0] d_spec_bits, fma_spec_bits;

   always_comb begin
      logic [31:0] a;
      logic [15:0] w;
      logic        a_nan, a_inf, a_zero, w_nan, w_inf, w_zero;
      logic        dn, di, tz, cn, ci, ps;
      a = in_ff.act_scale_single;
      w = in_ff.weight_scale_half;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      w_nan  = (w[14:10] == 5'h1F) && (w[9:0] != 10'd0);
      w_inf  = (w[14:10] == 5'h1F) && (w[9:0] == 10'd0);
      w_zero = (w[14:0] == 15'd0);
      d_special   = 1'b1;
      d_spec_bits = FP32_DEFAULT_NAN;
      if (a_nan) begin
         d_spec_bits = a | FP32_QUIET_BIT;
      end else if (w_nan) begin
         d_spec_bits = {w[15], 8'hFF, w[9:0], 13'd0} | FP32_QUIET_BIT;
      end else if ((a_inf && w_zero) || (w_inf && a_zero)) begin
         d_spec_bits = FP32_DEFAULT_NAN;
      end else if (a_inf || w_inf) begin
         d_spec_bits = {a[31] ^ w[15], 8'hFF, 23'd0};
      end else begin
         d_special = 1'b0;
      end

      dn = (d_ff[30:23] == 8'hFF) && (d_ff[22:0] != 23'd0);
      di = (d_ff[30:23] == 8'hFF) && (d_ff[22:0] == 23'd0);
      tz = (tf_ff[30:0] == 31'd0);
      cn = (acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] != 23'd0);
      ci = (acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] == 23'd0);
      ps = d_ff[31] ^ tf_ff[31];
      fma_special   = 1'b1;
      fma_spec_bits = FP32_DEFAULT_NAN;
      if (dn) begin
         fma_spec_bits = d_ff;
      end else if (di && tz) begin
         fma_spec_bits = FP32_DEFAULT_NAN;
      end else if (cn) begin
         fma_spec_bits = acc_ff;
      end else if (di) begin
         fma_spec_bits = (ci && (acc_ff[31] != ps)) ? FP32_DEFAULT_NAN
                                                    : {ps, 8'hFF, 23'd0};
      end else if (ci) begin
         fma_spec_bits = acc_ff;
      end else begin
         fma_special = 1'b0;
      end
   end

   // next values of the working registers
   always_comb begin
      logic [31:0]        tot_mag;
      logic [34:0]        prod_d;
      logic [47:0]        prod_p;
      logic signed [11:0] hexp;
      logic [10:0]        hsig;
      hsig = (in_ff.weight_scale_half[14:10] == 5'd0)
             ? {1'b0, in_ff.weight_scale_half[9:0]} : {1'b1, in_ff.weight_scale_half[9:0]};
      hexp = (in_ff.weight_scale_half[14:10] == 5'd0) ? -12'sd24
             : $signed({7'd0, in_ff.weight_scale_half[14:10]}) - 12'sd25;
      tot_mag = total_ff[31] ? (~total_ff + 32'd1) : total_ff;
      prod_d  = 35'(f32_sig(in_ff.act_scale_single)) * 35'(hsig);
      prod_p  = 48'(f32_sig(d_ff)) * 48'(f32_sig(tf_ff));

      total_in  = total_ff;
      sig_in    = sig_ff;
      x_in      = x_ff;
      sign_in   = sign_ff;
      sticky_in = sticky_ff;
      tf_in     = tf_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;

      if (cmd.do_total) begin
         total_in = total_ff + 32'(scaled_ff);
      end
      if (cmd.ld_tf) begin
         sig_in    = {48'd0, tot_mag};
         x_in      = '0;
         sign_in   = total_ff[31];
         sticky_in = 1'b0;
         total_in  = '0;
      end
      if (cmd.ld_d) begin
         sig_in    = 80'(prod_d);
         x_in      = f32_exp(in_ff.act_scale_single) + hexp;
         sign_in   = in_ff.act_scale_single[31] ^ in_ff.weight_scale_half[15];
         sticky_in = 1'b0;
      end
      if (cmd.ld_p) begin
         sig_in    = 80'(prod_p);
         x_in      = f32_exp(d_ff) + f32_exp(tf_ff);
         sign_in   = d_ff[31] ^ tf_ff[31];
         sticky_in = 1'b0;
      end
      if (cmd.ld_a) begin
         sig_in    = 80'(f32_sig(acc_ff));
         x_in      = f32_exp(acc_ff);
         sign_in   = acc_ff[31];
         sticky_in = 1'b0;
      end
      if (cmd.do_add) begin
         sig_in    = add_sig;
         x_in      = add_x;
         sign_in   = add_sign;
         sticky_in = 1'b0;
      end
      if (cmd.fix_step) begin
         if (do_l8) begin
            sig_in = sig_ff << 8;
            x_in   = x_ff - 12'sd8;
         end else if (do_l1) begin
            sig_in = sig_ff << 1;
            x_in   = x_ff - 12'sd1;
         end else if (do_r8) begin
            sig_in    = sig_ff >> 8;
            x_in      = x_ff + 12'sd8;
            sticky_in = sticky_ff | (|sig_ff[7:0]);
         end else if (do_r1) begin
            sig_in    = sig_ff >> 1;
            x_in      = x_ff + 12'sd1;
            sticky_in = sticky_ff | sig_ff[0];
         end
      end
      if (cmd.st_tf) begin
         tf_in = round_bits;
      end
      if (cmd.st_d) begin
         d_in = round_bits;
      end
      if (cmd.spec_d) begin
         d_in = d_spec_bits;
      end
      if (cmd.st_acc) begin
         acc_in = round_bits;
      end
      if (cmd.spec_acc) begin
         acc_in = fma_spec_bits;
      end
      if (cmd.emit) begin
         acc_in = FP32_POS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         acc_ff   <= FP32_POS_ZERO;
      end else begin
         total_ff <= total_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_payload;
      end
      if (cmd.do_mult) begin
         prod_ff <= prod_in;
      end
      if (cmd.do_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.do_scale) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.ld_a) begin
         p_sig_ff  <= sig_ff;
         p_x_ff    <= x_ff;
         p_sign_ff <= sign_ff;
      end
      if (cmd.emit) begin
         out_ff <= acc_ff;
      end
      sig_ff    <= sig_in;
      x_ff      <= x_in;
      sign_ff   <= sign_in;
      sticky_ff <= sticky_in;
      tf_ff     <= tf_in;
      d_ff      <= d_in;
   end

   always_comb begin
      stat.fold        = in_ff.ends_super_block | in_ff.ends_row;
      stat.row         = in_ff.ends_row;
      stat.fix_done    = !(do_l8 || do_l1 || do_r8 || do_r1);
      stat.d_special   = d_special;
      stat.fma_special = fma_special;
   end

   assign rsp_row_dot_bits = out_ff;

endmodule
`default_nettype wire

@@ src/q6kdot_controller.sv @@
// q6kdot_controller: sequencer for the dot, convert, scale and fused accumulate steps
// depends on q6kdot_pkg; drives q6kdot_datapath through its command struct
`default_nettype none
module q6kdot_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output q6kdot_pkg::dp_cmd_type   cmd,
   input  q6kdot_pkg::dp_stat_type  stat
);
   import q6kdot_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_MULT;
         ST_MULT:     state_in = ST_SUM;
         ST_SUM:      state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_TOTAL;
         ST_TOTAL:    state_in = stat.fold ? ST_TF_LOAD : ST_IDLE;
         ST_TF_LOAD:  state_in = ST_TF_FIX;
         ST_TF_FIX:   if (stat.fix_done) state_in = ST_TF_ROUND;
         ST_TF_ROUND: state_in = ST_D_LOAD;
         ST_D_LOAD:   state_in = stat.d_special ? ST_P_LOAD : ST_D_FIX;
         ST_D_FIX:    if (stat.fix_done) state_in = ST_D_ROUND;
         ST_D_ROUND:  state_in = ST_P_LOAD;
         ST_P_LOAD: begin
            if (stat.fma_special) begin
               state_in = stat.row ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_P_FIX;
            end
         end
         ST_P_FIX:    if (stat.fix_done) state_in = ST_A_LOAD;
         ST_A_LOAD:   state_in = ST_A_FIX;
         ST_A_FIX:    if (stat.fix_done) state_in = ST_ADD;
         ST_ADD:      state_in = ST_R_FIX;
         ST_R_FIX:    if (stat.fix_done) state_in = ST_R_ROUND;
         ST_R_ROUND:  state_in = stat.row ? ST_EMIT : ST_IDLE;
         ST_EMIT:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_MULT:     cmd.do_mult = 1'b1;
         ST_SUM:      cmd.do_sum = 1'b1;
         ST_SCALE:    cmd.do_scale = 1'b1;
         ST_TOTAL:    cmd.do_total = 1'b1;
         ST_TF_LOAD:  cmd.ld_tf = 1'b1;
         ST_TF_FIX: begin
            cmd.fix_step = 1'b1;
            cmd.floor_en = 1'b1;
         end
         ST_TF_ROUND: cmd.st_tf = 1'b1;
         ST_D_LOAD: begin
            cmd.spec_d = stat.d_special;
            cmd.ld_d   = !stat.d_special;
         end
         ST_D_FIX: begin
            cmd.fix_step = 1'b1;
            cmd.floor_en = 1'b1;
         end
         ST_D_ROUND:  cmd.st_d = 1'b1;
         ST_P_LOAD: begin
            cmd.spec_acc = stat.fma_special;
            cmd.ld_p     = !stat.fma_special;
         end
         ST_P_FIX:    cmd.fix_step = 1'b1;
         ST_A_LOAD:   cmd.ld_a = 1'b1;
         ST_A_FIX:    cmd.fix_step = 1'b1;
         ST_ADD:      cmd.do_add = 1'b1;
         ST_R_FIX: begin
            cmd.fix_step = 1'b1;
            cmd.floor_en = 1'b1;
         end
         ST_R_ROUND:  cmd.st_acc = 1'b1;
         ST_EMIT:     cmd.emit = rsp_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ src/q6k_q8k_block_dot.sv @@
// q6k by q8k block dot product, one 16-element sub-block per beat
// sequencing: an item that does not end a super-block passes the mult, sum, scale
// and total states and returns to idle before the next accept; an ending item adds
// the fp32 convert, scale product and fused accumulate through the shared
// normalize/round unit, which moves the frame 8 or 1 bit per step; a row end adds an emit state plus any wait
// reset: block total and row accumulator cleared to zero, no result pending
`default_nettype none
module q6k_q8k_block_dot (
   input  logic                 clock,
   input  logic                 reset,
   q6kdot_chan_if.sink          req_chan,
   q6kdot_chan_if.source        rsp_chan
);
   import q6kdot_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [31:0] row_bits;

   // sequencer: one item in flight, accepts only when idle
   q6kdot_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: integer dot, total, float convert, fused row accumulate
   q6kdot_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_payload      (req_chan.payload),
      .rsp_row_dot_bits (row_bits)
   );

   // result beat payload comes straight from the output register
   assign rsp_chan.payload.row_dot_bits = row_bits;

endmodule
`default_nettype wire
